FILE: design/i2cra_pkg.sv
// Shared types, codes and helpers for the I2C master register access sequencer.
`timescale 1ns / 1ps

package i2cra_pkg;

  // Request kinds carried in tuser
  localparam logic [1:0] OP_CMD   = 2'd0;
  localparam logic [1:0] OP_EVENT = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Command access kinds
  localparam logic [1:0] ACC_RD_BYTE = 2'd0;
  localparam logic [1:0] ACC_RD_WORD = 2'd1;
  localparam logic [1:0] ACC_WR_BYTE = 2'd2;
  localparam logic [1:0] ACC_WR_WORD = 2'd3;

  // Bus engine actions
  localparam logic [2:0] ACT_ACK_OFF = 3'd0;
  localparam logic [2:0] ACT_ACK_ON  = 3'd1;
  localparam logic [2:0] ACT_START   = 3'd2;
  localparam logic [2:0] ACT_SEND    = 3'd3;
  localparam logic [2:0] ACT_STOP    = 3'd4;
  localparam logic [2:0] ACT_DONE    = 3'd5;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_TIMEOUT = 1'b1;

  // Configuration register map
  localparam logic REG_TIMEOUT_LIMIT = 1'b0;
  localparam logic [15:0] TIMEOUT_RESET = 16'd50;

  // Result queue
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_AW    = $clog2(RES_DEPTH);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_T_SB,
    PH_T_ADDR,
    PH_T_TXE,
    PH_T_BTF,
    PH_R_SB,
    PH_R_ADDR,
    PH_R_FIRST,
    PH_R_LAST
  } phase_e;

  // One incoming request, unpacked
  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  access;
    logic [7:0]  slave_address;
    logic [7:0]  register_offset;
    logic [15:0] wr_value;
    logic        start_sent;
    logic        address_sent;
    logic        byte_finished;
    logic        tx_empty;
    logic        rx_ready;
    logic [7:0]  rx_byte;
  } req_t;

  // One action toward the bus engine
  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  byte_value;
    logic        status;
    logic [15:0] read_value;
  } res_t;

  // Up to two actions produced by one request
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } seq_out_t;

  // Queue entry
  typedef struct packed {
    res_t res;
    logic last;
  } out_item_t;

  function automatic res_t mk_res(logic [2:0] act, logic [7:0] byte_v, logic st,
                                  logic [15:0] rv);
    res_t r;
    r.action     = act;
    r.byte_value = byte_v;
    r.status     = st;
    r.read_value = rv;
    return r;
  endfunction

endpackage

FILE: design/i2cra_seq.sv
// Register access sequencer: phase state and actions for each request.
`timescale 1ns / 1ps

module i2cra_seq import i2cra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  req_t        req_i,
  input  logic [15:0] timeout_limit_i,
  output seq_out_t    seq_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  addr_q, addr_d;
  logic [7:0]  offset_q, offset_d;
  logic [15:0] value_q, value_d;
  logic [1:0]  byte_idx_q, byte_idx_d;
  logic [7:0]  first_q, first_d;
  logic [15:0] wait_q, wait_d;

  logic [15:0] wait_inc;
  logic        timeout;
  logic [1:0]  byte_next;
  logic [1:0]  tx_cnt;
  logic        tx_done;
  logic [7:0]  tx_byte;
  logic [15:0] rd_value;
  logic        is_word_rd;

  // Shared helpers
  assign wait_inc   = (wait_q == 16'hFFFF) ? wait_q : wait_q + 16'd1;
  assign timeout    = wait_inc > timeout_limit_i;
  assign byte_next  = byte_idx_q + 2'd1;
  assign tx_cnt     = kind_q[1] ? kind_q : 2'd1;
  assign tx_done    = byte_next >= tx_cnt;
  assign is_word_rd = kind_q == ACC_RD_WORD;
  assign rd_value   = is_word_rd ? {req_i.rx_byte, first_q} : {8'd0, req_i.rx_byte};

  always_comb begin
    unique case (byte_idx_q)
      2'd0:    tx_byte = offset_q;
      2'd1:    tx_byte = value_q[7:0];
      default: tx_byte = value_q[15:8];
    endcase
  end

  // Next state
  always_comb begin
    phase_d    = phase_q;
    kind_d     = kind_q;
    addr_d     = addr_q;
    offset_d   = offset_q;
    value_d    = value_q;
    byte_idx_d = byte_idx_q;
    first_d    = first_q;
    wait_d     = wait_q;
    if (req_valid_i) begin
      unique case (req_i.op)
        OP_CMD: begin
          if (phase_q == PH_IDLE) begin
            kind_d     = req_i.access;
            addr_d     = req_i.slave_address;
            offset_d   = req_i.register_offset;
            value_d    = req_i.wr_value;
            byte_idx_d = 2'd0;
            first_d    = 8'd0;
            phase_d    = PH_T_SB;
            wait_d     = 16'd0;
          end
        end
        OP_TICK: begin
          if (phase_q != PH_IDLE) begin
            if (timeout) begin
              phase_d = PH_IDLE;
              wait_d  = 16'd0;
            end else begin
              wait_d = wait_inc;
            end
          end
        end
        OP_EVENT: begin
          unique case (phase_q)
            PH_IDLE: ;
            PH_T_SB: if (req_i.start_sent) begin
              phase_d = PH_T_ADDR;
              wait_d  = 16'd0;
            end
            PH_T_ADDR: if (req_i.address_sent) begin
              byte_idx_d = 2'd0;
              phase_d    = PH_T_TXE;
              wait_d     = 16'd0;
            end
            PH_T_TXE: if (req_i.tx_empty) begin
              byte_idx_d = byte_next;
              phase_d    = tx_done ? PH_T_BTF : PH_T_TXE;
              wait_d     = 16'd0;
            end
            PH_T_BTF: if (req_i.byte_finished && req_i.tx_empty) begin
              phase_d = kind_q[1] ? PH_IDLE : PH_R_SB;
              wait_d  = 16'd0;
            end
            PH_R_SB: if (req_i.start_sent) begin
              phase_d = PH_R_ADDR;
              wait_d  = 16'd0;
            end
            PH_R_ADDR: if (req_i.address_sent) begin
              phase_d = is_word_rd ? PH_R_FIRST : PH_R_LAST;
              wait_d  = 16'd0;
            end
            PH_R_FIRST: if (req_i.rx_ready) begin
              first_d = req_i.rx_byte;
              phase_d = PH_R_LAST;
              wait_d  = 16'd0;
            end
            PH_R_LAST: if (req_i.rx_ready) begin
              phase_d = PH_IDLE;
              wait_d  = 16'd0;
            end
            default: phase_d = PH_IDLE;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Actions for the current request
  always_comb begin
    seq_o.count = 2'd0;
    seq_o.r0    = mk_res(ACT_ACK_OFF, 8'd0, STATUS_OK, 16'd0);
    seq_o.r1    = mk_res(ACT_ACK_OFF, 8'd0, STATUS_OK, 16'd0);
    if (req_valid_i) begin
      unique case (req_i.op)
        OP_CMD: begin
          if (phase_q == PH_IDLE) begin
            seq_o.count = 2'd2;
            seq_o.r1    = mk_res(ACT_START, 8'd0, STATUS_OK, 16'd0);
          end
        end
        OP_TICK: begin
          if (phase_q != PH_IDLE && timeout) begin
            seq_o.count = 2'd2;
            seq_o.r0    = mk_res(ACT_STOP, 8'd0, STATUS_OK, 16'd0);
            seq_o.r1    = mk_res(ACT_DONE, 8'd0, STATUS_TIMEOUT, 16'd0);
          end
        end
        OP_EVENT: begin
          unique case (phase_q)
            PH_T_SB: if (req_i.start_sent) begin
              seq_o.count = 2'd1;
              seq_o.r0    = mk_res(ACT_SEND, addr_q, STATUS_OK, 16'd0);
            end
            PH_T_TXE: if (req_i.tx_empty) begin
              seq_o.count = 2'd1;
              seq_o.r0    = mk_res(ACT_SEND, tx_byte, STATUS_OK, 16'd0);
            end
            PH_T_BTF: if (req_i.byte_finished && req_i.tx_empty) begin
              seq_o.count = 2'd2;
              if (kind_q[1]) begin
                seq_o.r0 = mk_res(ACT_STOP, 8'd0, STATUS_OK, 16'd0);
                seq_o.r1 = mk_res(ACT_DONE, 8'd0, STATUS_OK, 16'd0);
              end else begin
                seq_o.r0 = mk_res(is_word_rd ? ACT_ACK_ON : ACT_ACK_OFF, 8'd0,
                                  STATUS_OK, 16'd0);
                seq_o.r1 = mk_res(ACT_START, 8'd0, STATUS_OK, 16'd0);
              end
            end
            PH_R_SB: if (req_i.start_sent) begin
              seq_o.count = 2'd1;
              seq_o.r0    = mk_res(ACT_SEND, addr_q | 8'd1, STATUS_OK, 16'd0);
            end
            PH_R_ADDR: if (req_i.address_sent && !is_word_rd) begin
              seq_o.count = 2'd1;
              seq_o.r0    = mk_res(ACT_STOP, 8'd0, STATUS_OK, 16'd0);
            end
            PH_R_FIRST: if (req_i.rx_ready) begin
              seq_o.count = 2'd2;
              seq_o.r1    = mk_res(ACT_STOP, 8'd0, STATUS_OK, 16'd0);
            end
            PH_R_LAST: if (req_i.rx_ready) begin
              seq_o.count = 2'd1;
              seq_o.r0    = mk_res(ACT_DONE, 8'd0, STATUS_OK, rd_value);
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      kind_q     <= 2'd0;
      addr_q     <= 8'd0;
      offset_q   <= 8'd0;
      value_q    <= 16'd0;
      byte_idx_q <= 2'd0;
      first_q    <= 8'd0;
      wait_q     <= 16'd0;
    end else begin
      phase_q    <= phase_d;
      kind_q     <= kind_d;
      addr_q     <= addr_d;
      offset_q   <= offset_d;
      value_q    <= value_d;
      byte_idx_q <= byte_idx_d;
      first_q    <= first_d;
      wait_q     <= wait_d;
    end
  end

`ifndef ASSERT_OFF
  // No tick count survives in idle
  a_idle_wait_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> wait_q == 16'd0)
    else $error("wait count nonzero while idle");

  // A timeout always returns to idle
  a_timeout_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_i.op == OP_TICK && phase_q != PH_IDLE && timeout
    |=> phase_q == PH_IDLE)
    else $error("timeout did not return to idle");

  // A command taken in idle always emits ack off and start
  a_cmd_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_i.op == OP_CMD && phase_q == PH_IDLE |-> seq_o.count == 2'd2)
    else $error("command did not emit two actions");
`endif

endmodule

FILE: design/i2cra_rfifo.sv
// Result queue: takes up to two actions per cycle, hands out one per cycle while pop_i is high.
`timescale 1ns / 1ps

module i2cra_rfifo import i2cra_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  seq_out_t  push_i,
  input  logic      pop_i,
  output out_item_t head_o,
  output logic      valid_o,
  output logic      room_o
);

  out_item_t        mem_q [RES_DEPTH];
  logic [RES_AW-1:0] wptr_q, wptr_d;
  logic [RES_AW-1:0] rptr_q, rptr_d;
  logic [RES_AW:0]   cnt_q, cnt_d;
  logic [RES_AW-1:0] wptr_p1;
  logic              pop;

  assign valid_o = cnt_q != '0;
  assign room_o  = cnt_q <= (RES_AW + 1)'(RES_DEPTH - 2);
  assign head_o  = mem_q[rptr_q];
  assign pop     = pop_i && valid_o;
  assign wptr_p1 = wptr_q + 1'b1;

  // Pointer and fill count update
  always_comb begin
    wptr_d = wptr_q + RES_AW'(push_i.count);
    rptr_d = pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + (RES_AW + 1)'(push_i.count) - (RES_AW + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wptr_q] <= '{res: push_i.r0, last: push_i.count == 2'd1};
    end
    if (push_i.count == 2'd2) begin
      mem_q[wptr_p1] <= '{res: push_i.r1, last: 1'b1};
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> room_o)
    else $error("result queue written without room");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (RES_AW + 1)'(RES_DEPTH))
    else $error("result queue count out of range");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> rptr_q == $past(rptr_q) + 1'b1)
    else $error("read pointer did not advance on pop");
`endif

endmodule

FILE: design/i2c_master_register_access.sv
// Top level of the I2C master register access sequencer.
//
// Requests enter on the s_axis channel: tuser holds the kind (command, status
// event, timer tick) and tdata the command fields and event flags. Each request
// yields zero to two bus engine actions on the m_axis channel; tlast marks the
// final action of a request. The APB port holds timeout_limit at address 0.
//
// Actions for a request go through the result queue and leave on m_axis in order.
// One request per cycle is taken while the four-entry result queue has
// room for two more actions; the output drains one action per cycle while
// m_axis_tready is high, so s_axis_tready throttles two-action requests.
//
// Reset puts the sequencer in idle, empties the queue and loads timeout_limit
// with 50. When the receiver stalls, actions wait in the queue and s_axis_tready
// drops once fewer than two entries are free; nothing is lost or repeated.
`timescale 1ns / 1ps

module i2c_master_register_access import i2cra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: access[1:0], slave_address[9:2], register_offset[17:10],
  //   wr_value[33:18], start_sent[34], address_sent[35], byte_finished[36],
  //   tx_empty[37], rx_ready[38], rx_byte[46:39], zero[47]
  input  logic [47:0] s_axis_tdata,
  // tuser: op[1:0]
  input  logic [1:0]  s_axis_tuser,
  // Action channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: action[2:0], byte_value[10:3], status[11], read_value[27:12],
  //   zero[31:28]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] limit_q;
  logic        cfg_wr;
  logic        accept;
  req_t        req;
  seq_out_t    seq_out;
  out_item_t   head;
  logic        room;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_TIMEOUT_LIMIT) ? {16'd0, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= TIMEOUT_RESET;
    end else if (cfg_wr && paddr[2] == REG_TIMEOUT_LIMIT) begin
      limit_q <= pwdata[15:0];
    end
  end

  // Request unpacking
  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    req.op              = s_axis_tuser;
    req.access          = s_axis_tdata[1:0];
    req.slave_address   = s_axis_tdata[9:2];
    req.register_offset = s_axis_tdata[17:10];
    req.wr_value        = s_axis_tdata[33:18];
    req.start_sent      = s_axis_tdata[34];
    req.address_sent    = s_axis_tdata[35];
    req.byte_finished   = s_axis_tdata[36];
    req.tx_empty        = s_axis_tdata[37];
    req.rx_ready        = s_axis_tdata[38];
    req.rx_byte         = s_axis_tdata[46:39];
  end

  i2cra_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (accept),
    .req_i           (req),
    .timeout_limit_i (limit_q),
    .seq_o           (seq_out)
  );

  i2cra_rfifo u_rfifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (seq_out),
    .pop_i   (m_axis_tready),
    .head_o  (head),
    .valid_o (m_axis_tvalid),
    .room_o  (room)
  );

  // Action packing
  assign m_axis_tdata = {4'd0, head.res.read_value, head.res.status,
                         head.res.byte_value, head.res.action};
  assign m_axis_tlast = head.last;

endmodule

FILE: tb/i2c_master_register_access_tb.sv
// Self-checking testbench for the I2C master register access sequencer.
`timescale 1ns / 1ps

module i2c_master_register_access_tb;
  import i2cra_pkg::*;

  // Event flag masks, in the order the flags sit in tdata
  localparam logic [4:0] F_SB   = 5'b00001;
  localparam logic [4:0] F_ADDR = 5'b00010;
  localparam logic [4:0] F_BTF  = 5'b00100;
  localparam logic [4:0] F_TXE  = 5'b01000;
  localparam logic [4:0] F_RXNE = 5'b10000;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         HOLD_CYCLES = 300;
  localparam int         CYCLE_LIMIT = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: access, slave_address, register_offset, wr_value, start_sent,
  //   address_sent, byte_finished, tx_empty, rx_ready, rx_byte, zero
  logic [47:0] s_axis_tdata = '0;
  // tuser: op
  logic [1:0]  s_axis_tuser = OP_CMD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: action, byte_value, status, read_value, zero
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  i2c_master_register_access u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Sequencer copy kept by the testbench
  phase_e      bus_phase = PH_IDLE;
  logic [1:0]  acc_kind = '0;
  logic [7:0]  dev_addr = '0;
  logic [7:0]  reg_offset = '0;
  logic [15:0] wr_data = '0;
  logic [1:0]  tx_index = '0;
  logic [7:0]  rx_low = '0;
  logic [15:0] wait_count = '0;
  logic [15:0] tick_limit = TIMEOUT_RESET;

  req_t        pending_reqs[$];
  out_item_t   expected_actions[$];
  res_t        step_acts[$];
  req_t        offered_req;
  bit          req_taken = 1'b0;
  int          queued = 0;
  int          errors = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_asked = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  function automatic void add_act(logic [2:0] a, logic [7:0] b, logic st, logic [15:0] rv);
    res_t r;
    r.action     = a;
    r.byte_value = b;
    r.status     = st;
    r.read_value = rv;
    step_acts.push_back(r);
  endfunction

  function automatic void go(phase_e p);
    bus_phase  = p;
    wait_count = '0;
  endfunction

  // Work out the actions one accepted request causes and queue them up
  task automatic predict_actions(input req_t r);
    logic [7:0] b;
    logic [1:0] tx_total;
    out_item_t  e;
    step_acts.delete();
    case (r.op)
      OP_CMD: if (bus_phase == PH_IDLE) begin
        acc_kind   = r.access;
        dev_addr   = r.slave_address;
        reg_offset = r.register_offset;
        wr_data    = r.wr_value;
        tx_index   = '0;
        rx_low     = '0;
        add_act(ACT_ACK_OFF, 8'h00, STATUS_OK, 16'h0000);
        add_act(ACT_START, 8'h00, STATUS_OK, 16'h0000);
        go(PH_T_SB);
      end
      OP_TICK: if (bus_phase != PH_IDLE) begin
        if (wait_count != 16'hFFFF) wait_count++;
        if (wait_count > tick_limit) begin
          add_act(ACT_STOP, 8'h00, STATUS_OK, 16'h0000);
          add_act(ACT_DONE, 8'h00, STATUS_TIMEOUT, 16'h0000);
          go(PH_IDLE);
        end
      end
      OP_EVENT: begin
        case (bus_phase)
          PH_IDLE: ;
          PH_T_SB: if (r.start_sent) begin
            add_act(ACT_SEND, dev_addr, STATUS_OK, 16'h0000);
            go(PH_T_ADDR);
          end
          PH_T_ADDR: if (r.address_sent) begin
            tx_index = '0;
            go(PH_T_TXE);
          end
          PH_T_TXE: if (r.tx_empty) begin
            case (tx_index)
              2'd0:    b = reg_offset;
              2'd1:    b = wr_data[7:0];
              default: b = wr_data[15:8];
            endcase
            add_act(ACT_SEND, b, STATUS_OK, 16'h0000);
            tx_index++;
            tx_total = (acc_kind == ACC_WR_WORD) ? 2'd3 :
                       (acc_kind == ACC_WR_BYTE) ? 2'd2 : 2'd1;
            go((tx_index >= tx_total) ? PH_T_BTF : PH_T_TXE);
          end
          PH_T_BTF: if (r.byte_finished && r.tx_empty) begin
            if (acc_kind == ACC_WR_BYTE || acc_kind == ACC_WR_WORD) begin
              add_act(ACT_STOP, 8'h00, STATUS_OK, 16'h0000);
              add_act(ACT_DONE, 8'h00, STATUS_OK, 16'h0000);
              go(PH_IDLE);
            end else begin
              add_act((acc_kind == ACC_RD_WORD) ? ACT_ACK_ON : ACT_ACK_OFF, 8'h00,
                      STATUS_OK, 16'h0000);
              add_act(ACT_START, 8'h00, STATUS_OK, 16'h0000);
              go(PH_R_SB);
            end
          end
          PH_R_SB: if (r.start_sent) begin
            add_act(ACT_SEND, {dev_addr[7:1], 1'b1}, STATUS_OK, 16'h0000);
            go(PH_R_ADDR);
          end
          PH_R_ADDR: if (r.address_sent) begin
            if (acc_kind == ACC_RD_WORD) begin
              go(PH_R_FIRST);
            end else begin
              // single byte: NACK already set, stop goes out before the byte
              add_act(ACT_STOP, 8'h00, STATUS_OK, 16'h0000);
              go(PH_R_LAST);
            end
          end
          PH_R_FIRST: if (r.rx_ready) begin
            add_act(ACT_ACK_OFF, 8'h00, STATUS_OK, 16'h0000);
            add_act(ACT_STOP, 8'h00, STATUS_OK, 16'h0000);
            rx_low = r.rx_byte;
            go(PH_R_LAST);
          end
          PH_R_LAST: if (r.rx_ready) begin
            add_act(ACT_DONE, 8'h00, STATUS_OK,
                    (acc_kind == ACC_RD_WORD) ? {r.rx_byte, rx_low} : {8'h00, r.rx_byte});
            go(PH_IDLE);
          end
          default: bus_phase = PH_IDLE;
        endcase
      end
      default: ;
    endcase
    foreach (step_acts[i]) begin
      e.res  = step_acts[i];
      e.last = (i == step_acts.size() - 1);
      expected_actions.push_back(e);
    end
  endtask

  // Request with every field random, then the kind forced
  function automatic req_t rand_req(logic [1:0] op);
    logic [63:0] bits;
    req_t        r;
    bits = {$urandom, $urandom};
    r    = bits[$bits(req_t)-1:0];
    r.op = op;
    return r;
  endfunction

  function automatic req_t event_req(logic [4:0] flags, logic [7:0] rxb);
    req_t r;
    r = rand_req(OP_EVENT);
    {r.rx_ready, r.tx_empty, r.byte_finished, r.address_sent, r.start_sent} = flags;
    r.rx_byte = rxb;
    return r;
  endfunction

  function automatic void queue_req(req_t r);
    pending_reqs.push_back(r);
    queued++;
  endfunction

  // One bus wait: a few ticks, maybe a stray event, then the awaited event.
  // When cut, the wait runs past the tick limit instead.
  task automatic step_wait(input logic [4:0] need, input logic [7:0] rxb, input bit plain,
                           input bit cut);
    int         n;
    logic [4:0] junk;
    if (cut) begin
      repeat (int'(tick_limit) + 1) queue_req(rand_req(OP_TICK));
    end else begin
      if (!plain) begin
        n = $urandom_range(0, (tick_limit < 3) ? tick_limit : 3);
        if ($urandom_range(0, 15) == 0 && tick_limit <= 64) n = tick_limit;
        repeat (n) queue_req(rand_req(OP_TICK));
        if ($urandom_range(0, 3) == 0) begin
          junk = 5'($urandom);
          if ((junk & need) == need) junk &= ~(need & (~need + 5'd1));
          queue_req(event_req(junk, 8'($urandom)));
        end
      end
      queue_req(event_req(plain ? need : (need | 5'($urandom)), rxb));
    end
  endtask

  // Full register access as the bus engine would report it
  task automatic run_access(input logic [1:0] acc, input logic [7:0] sa, input logic [7:0] ro,
                            input logic [15:0] wv, input logic [7:0] rx_lo,
                            input logic [7:0] rx_hi, input int cut_at, input bit plain);
    req_t       c;
    logic [4:0] waits[$];
    logic [7:0] rxb;
    int         rx_seen;
    c                 = rand_req(OP_CMD);
    c.access          = acc;
    c.slave_address   = sa;
    c.register_offset = ro;
    c.wr_value        = wv;
    queue_req(c);
    if (!plain && $urandom_range(0, 5) == 0) queue_req(rand_req(OP_CMD));
    waits.push_back(F_SB);
    waits.push_back(F_ADDR);
    repeat ((acc == ACC_WR_WORD) ? 3 : (acc == ACC_WR_BYTE) ? 2 : 1) waits.push_back(F_TXE);
    waits.push_back(F_BTF | F_TXE);
    if (acc == ACC_RD_BYTE || acc == ACC_RD_WORD) begin
      waits.push_back(F_SB);
      waits.push_back(F_ADDR);
      if (acc == ACC_RD_WORD) waits.push_back(F_RXNE);
      waits.push_back(F_RXNE);
    end
    rx_seen = 0;
    foreach (waits[i]) begin
      rxb = 8'($urandom);
      if (waits[i] == F_RXNE) begin
        rxb = (rx_seen == 0) ? rx_lo : rx_hi;
        rx_seen++;
      end
      step_wait(waits[i], rxb, plain, i == cut_at);
      if (i == cut_at) return;
    end
    // now idle: events, ticks and the unused op are all dropped
    if (!plain && $urandom_range(0, 7) == 0) queue_req(rand_req(2'($urandom_range(1, 3))));
  endtask

  task automatic random_accesses(input int count);
    int stop_at;
    int cut;
    stop_at = queued + count;
    while (queued < stop_at) begin
      cut = (tick_limit <= 64 && $urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : -1;
      run_access(2'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                 8'($urandom), cut, 1'b0);
    end
  endtask

  // One APB transfer on timeout_limit; a read is checked against the local copy
  task automatic apb_access(input bit wr, input logic [15:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_TIMEOUT_LIMIT, 2'b00};
    pwdata  <= {16'h0000, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (wr) begin
      tick_limit = val;
    end else if (prdata[15:0] !== tick_limit) begin
      $error("timeout_limit: expected %0d, got %0d", tick_limit, prdata[15:0]);
      errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_limit(input logic [15:0] val);
    apb_access(1'b1, val);
    apb_access(1'b0, 16'h0000);
  endtask

  // Let the sender run dry and every action come back
  task automatic drain();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_actions.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || req_taken)) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        offered_req = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= offered_req.op;
        s_axis_tdata  <= {1'b0, offered_req.rx_byte, offered_req.rx_ready,
                          offered_req.tx_empty, offered_req.byte_finished,
                          offered_req.address_sent, offered_req.start_sent,
                          offered_req.wr_value, offered_req.register_offset,
                          offered_req.slave_address, offered_req.access};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Action receiver, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_served != hold_asked) begin
      hold_left = HOLD_CYCLES;
      hold_served++;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on accepted requests, check accepted actions
  always @(posedge clk_i) begin
    out_item_t e;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      req_taken = 1'b0;
      if (rst_ni) begin
        if (s_axis_tvalid && s_axis_tready) begin
          req_taken = 1'b1;
          predict_actions(offered_req);
        end
        if (m_axis_tvalid && m_axis_tready) begin
          if (expected_actions.size() == 0) begin
            $error("unexpected action: tdata %h, tlast %b", m_axis_tdata, m_axis_tlast);
            errors++;
          end else begin
            e = expected_actions.pop_front();
            if (m_axis_tdata[2:0] !== e.res.action) begin
              $error("action: expected %0d, got %0d", e.res.action, m_axis_tdata[2:0]);
              errors++;
            end
            if (m_axis_tdata[10:3] !== e.res.byte_value) begin
              $error("byte_value: expected %0h, got %0h", e.res.byte_value,
                     m_axis_tdata[10:3]);
              errors++;
            end
            if (m_axis_tdata[11] !== e.res.status) begin
              $error("status: expected %0d, got %0d", e.res.status, m_axis_tdata[11]);
              errors++;
            end
            if (m_axis_tdata[27:12] !== e.res.read_value) begin
              $error("read_value: expected %0h, got %0h", e.res.read_value,
                     m_axis_tdata[27:12]);
              errors++;
            end
            if (m_axis_tlast !== e.last) begin
              $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
              errors++;
            end
          end
        end
      end
    end
  end

  // Test sequence
  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset value of the limit, then directed cases, no idling
    apb_access(1'b0, 16'h0000);
    queue_req(rand_req(OP_UNUSED));
    queue_req(event_req(5'b11111, 8'hFF));
    queue_req(rand_req(OP_TICK));
    run_access(ACC_WR_WORD, 8'hFF, 8'h00, 16'hFFFF, 8'h00, 8'h00, -1, 1'b1);
    run_access(ACC_RD_WORD, 8'h00, 8'hFF, 16'h0000, 8'hFF, 8'h00, -1, 1'b1);
    random_accesses(90);
    drain();

    // limit of 1, sender idle most of the time; includes timeout after early stop
    set_limit(16'd1);
    send_idle_pct = 75;
    run_access(ACC_RD_BYTE, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
               8'($urandom), 6, 1'b0);
    random_accesses(90);
    drain();

    // largest limit: a long wait never times out; receiver stalls
    set_limit(16'hFFFF);
    send_idle_pct  = 0;
    recv_stall_pct = 75;
    queue_req(rand_req(OP_CMD));
    pending_reqs[$].access = ACC_WR_BYTE;
    repeat (20) queue_req(rand_req(OP_TICK));
    queue_req(event_req(F_SB, 8'h00));
    queue_req(event_req(F_ADDR, 8'h00));
    queue_req(event_req(F_TXE, 8'h00));
    queue_req(event_req(F_TXE, 8'h00));
    queue_req(event_req(F_BTF | F_TXE, 8'h00));
    random_accesses(90);
    drain();

    // small random limit, both sides idle now and then
    set_limit(16'($urandom_range(2, 40)));
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    random_accesses(90);
    drain();

    // receiver holds off for a long stretch while requests keep coming
    set_limit(16'($urandom_range(41, 65534)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_asked++;
    random_accesses(90);
    drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
